/* hdl/vector_refraction_macros.svh */
// Assertion helpers for the checker.
`ifndef VECTOR_REFRACTION_MACROS_SVH
`define VECTOR_REFRACTION_MACROS_SVH

// Implication in the same cycle.
`define VR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("vector_refraction assertion failed");

// Implication in the next cycle.
`define VR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("vector_refraction assertion failed");

`endif

/* hdl/vr_pkg.sv */
package vr_pkg;

  localparam int unsigned Latency = 17;
  localparam int unsigned SqrtStages = 7;
  localparam int unsigned SqrtStepsPerStage = 3;

  typedef struct packed {
    logic [2:0][15:0] inc;
    logic [2:0][15:0] nrm;
    logic [15:0]      eta;
  } ray_t;

  typedef struct packed {
    logic [2:0][15:0] inc;
    logic [2:0][16:0] nn;
    logic [33:0]      dot2;
    logic [15:0]      eta;
  } dot_t;

  typedef struct packed {
    logic [2:0][15:0] inc;
    logic [2:0][16:0] nn;
    logic [2:0][30:0] tmp;
    logic             refl;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [40:0] len;
  } tan_t;

  typedef struct packed {
    side_t       side;
    logic [20:0] root;
  } root_t;

  typedef struct packed {
    logic [41:0] rad;
    logic [22:0] rem;
    logic [20:0] root;
  } sq_t;

  // One radix-4 digit of a restoring integer square root.
  function automatic sq_t sqrt_step(sq_t s);
    sq_t         r;
    logic [24:0] cur;
    logic [24:0] trial;
    cur   = {s.rem, s.rad[41:40]};
    trial = {2'b00, s.root, 2'b01};
    r.rad = {s.rad[39:0], 2'b00};
    if (cur >= trial) begin
      r.rem  = 23'(cur - trial);
      r.root = {s.root[19:0], 1'b1};
    end else begin
      r.rem  = cur[22:0];
      r.root = {s.root[19:0], 1'b0};
    end
    return r;
  endfunction

endpackage

/* hdl/vr_dot.sv */
module vr_dot (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  vr_pkg::ray_t  ray_i,
  output logic          valid_o,
  output vr_pkg::dot_t  dot_o
);

  logic                    v1_q;
  vr_pkg::ray_t            ray1_q;
  logic signed [31:0]      prod1_q [3];
  logic                    v2_q;
  vr_pkg::dot_t            dot2_q;
  logic signed [33:0]      dot;
  logic                    flip;
  vr_pkg::dot_t            dot_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ray1_q <= ray_i;
    for (int k = 0; k < 3; k++) begin
      prod1_q[k] <= $signed(ray_i.inc[k]) * $signed(ray_i.nrm[k]);
    end
    dot2_q <= dot_d;
  end

  always_comb begin
    dot   = 34'(prod1_q[0]) + 34'(prod1_q[1]) + 34'(prod1_q[2]);
    flip  = !dot[33] && (dot != '0);
    dot_d.inc  = ray1_q.inc;
    dot_d.eta  = ray1_q.eta;
    // normal turned to face the incident ray; dot product follows it
    dot_d.dot2 = flip ? 34'(-dot) : dot;
    for (int k = 0; k < 3; k++) begin
      dot_d.nn[k] = flip ? 17'(-$signed({ray1_q.nrm[k][15], ray1_q.nrm[k]}))
                         : {ray1_q.nrm[k][15], ray1_q.nrm[k]};
    end
  end

  assign valid_o = v2_q;
  assign dot_o   = dot2_q;

endmodule

/* hdl/vr_tangent.sv */
module vr_tangent (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  vr_pkg::dot_t  dot_i,
  output logic          valid_o,
  output vr_pkg::tan_t  tan_o
);

  logic [5:0]               v_q;
  // stage 3: normal times dot
  logic [2:0][15:0]         inc3_q, inc4_q, inc5_q, inc6_q, inc7_q;
  logic [2:0][16:0]         nn3_q, nn4_q, nn5_q, nn6_q, nn7_q;
  logic [15:0]              eta3_q, eta4_q;
  logic signed [50:0]       p3_q [3];
  // stage 4: tangent rounded to Q28
  logic signed [35:0]       t28_q [3];
  // stage 5: scaled by eta
  logic signed [52:0]       p5_q [3];
  // stage 6: tmp in Q20
  logic [2:0][30:0]         tmp6_q, tmp7_q;
  // stage 7: squares
  logic [60:0]              sq7_q [3];
  // stage 8
  vr_pkg::tan_t             tan8_q;

  logic signed [51:0]       t42 [3];
  logic signed [51:0]       t42r [3];
  logic signed [52:0]       p5r [3];
  logic [2:0][30:0]         tmp_d;
  logic [62:0]              sqsum;
  logic signed [63:0]       len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t42[k]  = (52'($signed(inc3_q[k])) <<< 28) - 52'(p3_q[k]);
      t42r[k] = t42[k] + 52'sd8192;
      p5r[k]  = p5_q[k] + 53'sd524288;
      tmp_d[k] = p5r[k][50:20];
    end
    sqsum = 63'(sq7_q[0]) + 63'(sq7_q[1]) + 63'(sq7_q[2]);
    len   = (64'sd1 <<< 40) - $signed({1'b0, sqsum});
  end

  always_ff @(posedge clk_i) begin
    inc3_q <= dot_i.inc;
    nn3_q  <= dot_i.nn;
    eta3_q <= dot_i.eta;
    for (int k = 0; k < 3; k++) begin
      p3_q[k] <= $signed(dot_i.nn[k]) * $signed(dot_i.dot2);
    end

    inc4_q <= inc3_q;
    nn4_q  <= nn3_q;
    eta4_q <= eta3_q;
    for (int k = 0; k < 3; k++) begin
      t28_q[k] <= t42r[k][49:14];
    end

    inc5_q <= inc4_q;
    nn5_q  <= nn4_q;
    for (int k = 0; k < 3; k++) begin
      p5_q[k] <= t28_q[k] * $signed({1'b0, eta4_q});
    end

    inc6_q <= inc5_q;
    nn6_q  <= nn5_q;
    tmp6_q <= tmp_d;

    inc7_q <= inc6_q;
    nn7_q  <= nn6_q;
    tmp7_q <= tmp6_q;
    for (int k = 0; k < 3; k++) begin
      sq7_q[k] <= 61'($signed(tmp6_q[k]) * $signed(tmp6_q[k]));
    end

    tan8_q.side.inc  <= inc7_q;
    tan8_q.side.nn   <= nn7_q;
    tan8_q.side.tmp  <= tmp7_q;
    tan8_q.side.refl <= len[63];
    tan8_q.len       <= len[40:0];
  end

  assign valid_o = v_q[5];
  assign tan_o   = tan8_q;

endmodule

/* hdl/vr_sqrt.sv */
module vr_sqrt (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  vr_pkg::tan_t  tan_i,
  output logic          valid_o,
  output vr_pkg::root_t root_o
);

  logic [vr_pkg::SqrtStages-1:0] v_q;
  vr_pkg::sq_t                   st_q   [vr_pkg::SqrtStages];
  vr_pkg::side_t                 side_q [vr_pkg::SqrtStages];
  vr_pkg::sq_t                   st_d   [vr_pkg::SqrtStages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[vr_pkg::SqrtStages-2:0], valid_i};
    end
  end

  for (genvar g = 0; g < vr_pkg::SqrtStages; g++) begin : g_stage
    vr_pkg::sq_t   st_in;
    vr_pkg::side_t side_in;

    if (g == 0) begin : g_first
      assign st_in   = '{rad: {1'b0, tan_i.len}, rem: '0, root: '0};
      assign side_in = tan_i.side;
    end else begin : g_next
      assign st_in   = st_q[g-1];
      assign side_in = side_q[g-1];
    end

    always_comb begin
      vr_pkg::sq_t s;
      s = st_in;
      for (int i = 0; i < vr_pkg::SqrtStepsPerStage; i++) begin
        s = vr_pkg::sqrt_step(s);
      end
      st_d[g] = s;
    end

    always_ff @(posedge clk_i) begin
      st_q[g]   <= st_d[g];
      side_q[g] <= side_in;
    end
  end

  assign valid_o     = v_q[vr_pkg::SqrtStages-1];
  assign root_o.side = side_q[vr_pkg::SqrtStages-1];
  assign root_o.root = st_q[vr_pkg::SqrtStages-1].root;

endmodule

/* hdl/vr_combine.sv */
module vr_combine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  vr_pkg::root_t        root_i,
  output logic                 valid_o,
  output logic [2:0][15:0]     vec_o,
  output logic                 refl_o
);

  logic                  v1_q, v2_q;
  vr_pkg::side_t         side1_q;
  logic signed [38:0]    p1_q [3];
  logic [2:0][15:0]      vec2_q;
  logic                  refl2_q;

  logic signed [45:0]    r34 [3];
  logic signed [45:0]    r34r [3];
  logic signed [25:0]    q [3];
  logic [2:0][15:0]      vec_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      r34[k]  = (46'($signed(side1_q.tmp[k])) <<< 14) - 46'(p1_q[k]);
      r34r[k] = r34[k] + 46'sd524288;
      q[k]    = r34r[k][45:20];
      if (side1_q.refl) begin
        vec_d[k] = side1_q.inc[k];
      end else if (q[k] > 26'sd32767) begin
        vec_d[k] = 16'h7fff;
      end else if (q[k] < -26'sd32768) begin
        vec_d[k] = 16'h8000;
      end else begin
        vec_d[k] = q[k][15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    side1_q <= root_i.side;
    for (int k = 0; k < 3; k++) begin
      p1_q[k] <= 39'($signed(root_i.side.nn[k]) * $signed({1'b0, root_i.root}));
    end
    vec2_q  <= vec_d;
    refl2_q <= side1_q.refl;
  end

  assign valid_o = v2_q;
  assign vec_o   = vec2_q;
  assign refl_o  = refl2_q;

endmodule

/* hdl/vector_refraction.sv */
// Snell refraction of one 3D ray per item, Q2.14 vectors, Q4.12 eta.
// An accepted item passes through vr_dot, vr_tangent, vr_sqrt and vr_combine in turn; done_o marks its result.
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// The square root takes seven stages of three radix-4 digits each.
// Reset clears only the valid bits; no result appears until an item enters.
module vector_refraction (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  output logic        done_o,
  input  logic [15:0] inc_x_i,
  input  logic [15:0] inc_y_i,
  input  logic [15:0] inc_z_i,
  input  logic [15:0] nrm_x_i,
  input  logic [15:0] nrm_y_i,
  input  logic [15:0] nrm_z_i,
  input  logic [15:0] index_ratio_i,
  output logic [15:0] out_x_o,
  output logic [15:0] out_y_o,
  output logic [15:0] out_z_o,
  output logic        total_reflect_o
);

  vr_pkg::ray_t   ray;
  logic           dot_v, tan_v, root_v;
  vr_pkg::dot_t   dot;
  vr_pkg::tan_t   tan;
  vr_pkg::root_t  root;
  logic [2:0][15:0] vec;

  assign busy = 1'b0;

  assign ray.inc = {inc_z_i, inc_y_i, inc_x_i};
  assign ray.nrm = {nrm_z_i, nrm_y_i, nrm_x_i};
  assign ray.eta = index_ratio_i;

  vr_dot u_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .ray_i   (ray),
    .valid_o (dot_v),
    .dot_o   (dot)
  );

  vr_tangent u_tan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dot_v),
    .dot_i   (dot),
    .valid_o (tan_v),
    .tan_o   (tan)
  );

  vr_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (tan_v),
    .tan_i   (tan),
    .valid_o (root_v),
    .root_o  (root)
  );

  vr_combine u_comb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (root_v),
    .root_i  (root),
    .valid_o (done_o),
    .vec_o   (vec),
    .refl_o  (total_reflect_o)
  );

  assign out_x_o = vec[0];
  assign out_y_o = vec[1];
  assign out_z_o = vec[2];

endmodule

/* hdl/vr_checker.sv */
`include "vector_refraction_macros.svh"

module vr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [15:0] inc_x_i,
  input logic [15:0] index_ratio_i,
  input logic [15:0] out_x_o,
  input logic        total_reflect_o
);

  // every accepted item comes out after the fixed latency, and only then
  `VR_ASSERT_IMP(a_done_has_item, clk_i, rst_ni, done_o, $past(start && !busy, 17))
  `VR_ASSERT_IMP(a_item_gets_done, clk_i, rst_ni, start && !busy, ##17 done_o)
  // total reflection hands back the incident vector
  `VR_ASSERT_IMP(a_refl_passthru, clk_i, rst_ni, done_o && total_reflect_o,
                 out_x_o == $past(inc_x_i, 17))
  // zero eta leaves L at one, never reflective
  `VR_ASSERT_IMP(a_zero_eta, clk_i, rst_ni, done_o && $past(index_ratio_i == 16'd0, 17),
                 !total_reflect_o)
  `VR_ASSERT_NXT(a_never_busy, clk_i, rst_ni, 1'b1, !busy)

endmodule

bind vector_refraction vr_checker u_vr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .inc_x_i         (inc_x_i),
  .index_ratio_i   (index_ratio_i),
  .out_x_o         (out_x_o),
  .total_reflect_o (total_reflect_o)
);
